// ===== rtl/llpc_pkg.sv =====
package llpc_pkg;

	// datapath word for products and quotients
	localparam int PROD_W = 20;
	localparam int DIV_A  = 255;

	localparam int NUM_SLOTS = 5;
	localparam int RAMP_LEN  = 8;
	localparam logic [6:0] PCT_FULL = 7'd100;

	localparam logic [2:0] TYPE_BATTERY   = 3'd2;
	localparam logic [2:0] TYPE_BACKLIGHT = 3'd3;
	localparam logic [2:0] TYPE_BUTTONS   = 3'd4;

	localparam logic [7:0] LUMA_WR = 8'd77;
	localparam logic [7:0] LUMA_WG = 8'd150;
	localparam logic [7:0] LUMA_WB = 8'd29;

	localparam logic [1:0] CH_R = 2'd0;
	localparam logic [1:0] CH_G = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;

	localparam logic [1:0] CFG_STEP = 2'd0;
	localparam logic [1:0] CFG_LCD  = 2'd1;
	localparam logic [1:0] CFG_LED  = 2'd2;

	localparam logic [11:0] STEP_RST = 12'd50;
	localparam logic [11:0] LCD_RST  = 12'd4095;
	localparam logic [7:0]  LED_RST  = 8'd255;

	localparam int UA_W = 6;

	typedef enum logic [3:0] {
		TGT_LCD      = 4'd0,
		TGT_BUTTON   = 4'd1,
		TGT_BUTTON1  = 4'd2,
		TGT_BLINK    = 4'd3,
		TGT_START    = 4'd4,
		TGT_DUTY     = 4'd5,
		TGT_PAUSE_LO = 4'd6,
		TGT_PAUSE_HI = 4'd7,
		TGT_STEP     = 4'd8,
		TGT_WHITE    = 4'd9,
		TGT_UNSUP    = 4'd10
	} tgt_t;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_PICK,
		OP_MULA,
		OP_TAKEA,
		OP_MAC,
		OP_MULM,
		OP_TAKEW,
		OP_LDON,
		OP_STEP,
		OP_MULD,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		V_ZERO,
		V_ONE,
		V_W,
		V_DUTY,
		V_OFF,
		V_PAUSE,
		V_STEP
	} vsrc_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_UNSUP,
		C_GRP_BL,
		C_GRP_BTN,
		C_NOT_TIMED,
		C_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		logic [1:0]      chan;
		tgt_t            tgt;
		vsrc_t           vsrc;
		logic            last;
		cond_t           cond;
		logic [UA_W-1:0] jaddr;
	} ucode_t;

	localparam logic [UA_W-1:0] A_DUTY  = 6'd27;
	localparam logic [UA_W-1:0] A_WHITE = 6'd35;
	localparam logic [UA_W-1:0] A_BL    = 6'd36;
	localparam logic [UA_W-1:0] A_BTN   = 6'd37;
	localparam logic [UA_W-1:0] A_ERR   = 6'd39;

	function automatic logic [6:0] ramp_pct(input logic [2:0] k);
		logic [6:0] p;
		case (k)
			3'd0: p = 7'd0;
			3'd1: p = 7'd12;
			3'd2: p = 7'd25;
			3'd3: p = 7'd37;
			3'd4: p = 7'd50;
			3'd5: p = 7'd72;
			3'd6: p = 7'd85;
			default: p = 7'd100;
		endcase
		return p;
	endfunction

	function automatic ucode_t uword(input op_t op, input logic [1:0] chan, input tgt_t tgt,
			input vsrc_t vsrc, input logic last, input cond_t cond,
			input logic [UA_W-1:0] jaddr);
		ucode_t w;
		w.op    = op;
		w.chan  = chan;
		w.tgt   = tgt;
		w.vsrc  = vsrc;
		w.last  = last;
		w.cond  = cond;
		w.jaddr = jaddr;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(input logic [UA_W-1:0] a);
		ucode_t w;
		w = uword(OP_WAIT, CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
		case (a)
			6'd0:  w = uword(OP_PICK,  CH_R, TGT_LCD, V_ZERO, 1'b0, C_UNSUP, A_ERR);
			6'd1:  w = uword(OP_MULA,  CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd4:  w = uword(OP_TAKEA, CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd5:  w = uword(OP_MULA,  CH_G, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd8:  w = uword(OP_TAKEA, CH_G, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd9:  w = uword(OP_MULA,  CH_B, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd12: w = uword(OP_TAKEA, CH_B, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd13: w = uword(OP_MAC,   CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd14: w = uword(OP_MAC,   CH_G, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd15: w = uword(OP_MAC,   CH_B, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd16: w = uword(OP_MULM,  CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd19: w = uword(OP_TAKEW, CH_R, TGT_LCD, V_ZERO, 1'b0, C_GRP_BL, A_BL);
			6'd20: w = uword(OP_WAIT,  CH_R, TGT_LCD, V_ZERO, 1'b0, C_GRP_BTN, A_BTN);
			6'd21: w = uword(OP_EMIT, CH_R, TGT_BLINK, V_ZERO, 1'b0, C_NOT_TIMED, A_WHITE);
			6'd22: w = uword(OP_LDON,  CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd25: w = uword(OP_STEP,  CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd26: w = uword(OP_EMIT,  CH_R, TGT_START, V_ZERO, 1'b0, C_NONE, '0);
			6'd27: w = uword(OP_MULD,  CH_R, TGT_LCD, V_ZERO, 1'b0, C_NONE, '0);
			6'd30: w = uword(OP_EMIT,  CH_R, TGT_DUTY, V_DUTY, 1'b0, C_MORE, A_DUTY);
			6'd31: w = uword(OP_EMIT,  CH_R, TGT_PAUSE_LO, V_OFF, 1'b0, C_NONE, '0);
			6'd32: w = uword(OP_EMIT,  CH_R, TGT_PAUSE_HI, V_PAUSE, 1'b0, C_NONE, '0);
			6'd33: w = uword(OP_EMIT,  CH_R, TGT_STEP, V_STEP, 1'b0, C_NONE, '0);
			6'd34: w = uword(OP_EMIT,  CH_R, TGT_BLINK, V_ONE, 1'b1, C_NONE, '0);
			6'd35: w = uword(OP_EMIT,  CH_R, TGT_WHITE, V_W, 1'b1, C_NONE, '0);
			6'd36: w = uword(OP_EMIT,  CH_R, TGT_LCD, V_W, 1'b1, C_NONE, '0);
			6'd37: w = uword(OP_EMIT,  CH_R, TGT_BUTTON, V_W, 1'b0, C_NONE, '0);
			6'd38: w = uword(OP_EMIT,  CH_R, TGT_BUTTON1, V_W, 1'b1, C_NONE, '0);
			6'd39: w = uword(OP_EMIT,  CH_R, TGT_UNSUP, V_ZERO, 1'b1, C_NONE, '0);
			default: ;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/llpc_cdiv.sv =====
// Two-stage divide by a constant: reciprocal estimate, then one correction.
module llpc_cdiv
	import llpc_pkg::*;
#(
	parameter int DIV_B = 16
) (
	input  logic              clk,
	input  logic [PROD_W-1:0] x,
	input  logic              sel_b,
	output logic [PROD_W-1:0] q
);

	localparam int PW2 = 2 * PROD_W;
	localparam logic [PROD_W-1:0] RECIP_A = PROD_W'((1 << PROD_W) / DIV_A);
	localparam logic [PROD_W-1:0] RECIP_B = PROD_W'((1 << PROD_W) / DIV_B);

	logic [PW2-1:0]    prod;
	logic [PROD_W-1:0] x_s1, est_s1, back, rem, dv;
	logic              sel_s1;
	logic [PROD_W-1:0] q_s2;

	// estimate never exceeds the quotient and trails it by at most one
	assign prod = PW2'(x) * PW2'(sel_b ? RECIP_B : RECIP_A);
	assign dv   = sel_s1 ? PROD_W'(DIV_B) : PROD_W'(DIV_A);
	assign back = sel_s1 ? est_s1 * PROD_W'(DIV_B) : est_s1 * PROD_W'(DIV_A);
	assign rem  = x_s1 - back;

	always_ff @(posedge clk) begin
		x_s1   <= x;
		sel_s1 <= sel_b;
		est_s1 <= prod[PW2-1:PROD_W];
		q_s2   <= (rem >= dv) ? est_s1 + 1'b1 : est_s1;
	end

	assign q = q_s2;

endmodule

// ===== rtl/led_light_priority_controller.sv =====
// Light request controller. Each input beat is one light request: the type on s_axis_tuser,
// and ARGB color, timed-flash flag and on/off times on s_axis_tdata. The request is cached
// in the slot of its type (attention, notifications and battery share the white LED, in
// that priority; backlight and buttons stand alone), the first lit slot of its group is
// chosen, its alpha-scaled luma is scaled to the group's full-scale register, and the LED
// register writes come out as beats on m_axis, tuser naming the target register and tlast
// marking the final write of the request. A short microprogram steps a datapath with a
// multiplier shared by the scaling steps and a two-stage divide-by-constant unit; each waits on
// that pair for its quotient. The next request is taken as soon as the last write sits in
// the output register. Registers sit on the APB port at 0x0 (default ramp step ms), 0x4
// (backlight full scale) and 0x8 (LED full scale).
module led_light_priority_controller
	import llpc_pkg::*;
#(
	parameter int NUM_RAMP_STEPS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// request beat
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] argb_color, [32] timed_flash, [48:33] on_time_ms, [64:49] off_time_ms
	input  logic [71:0] s_axis_tdata,
	// [2:0] light_type
	input  logic [2:0]  s_axis_tuser,
	// register write beat
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] write_value, [18:16] duty_index
	output logic [23:0] m_axis_tdata,
	// [3:0] target_reg
	output logic [3:0]  m_axis_tuser,
	output logic        m_axis_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TWO_N = 2 * NUM_RAMP_STEPS;
	localparam int IW    = $clog2(NUM_RAMP_STEPS);
	localparam logic [IW-1:0] I_LAST = IW'(NUM_RAMP_STEPS - 1);

	// configuration registers
	logic [11:0] step_def_q, lcd_max_q;
	logic [7:0]  led_max_q;
	logic        cfg_wr;

	// request fields
	logic        in_acc;
	logic [2:0]  in_type;
	logic [31:0] in_argb;
	logic        in_timed;
	logic [15:0] in_on, in_off;

	// slot cache
	logic [31:0] slot_color_q [NUM_SLOTS];
	logic        slot_timed_q [NUM_SLOTS];
	logic [15:0] slot_on_q    [NUM_SLOTS];
	logic [15:0] slot_off_q   [NUM_SLOTS];

	// sequencer
	logic [UA_W-1:0] pc_q;
	logic            busy_q;
	logic [IW-1:0]   i_q;
	ucode_t          uw;
	logic            is_emit, out_free, advance, emit_go, jump;

	// datapath
	logic [2:0]        type_q;
	logic [31:0]       color_q;
	logic              timed_q;
	logic [15:0]       on_q, off_q;
	logic [7:0]        ch_q [3];
	logic [PROD_W-1:0] prod_q;
	logic              dsel_q;
	logic [15:0]       acc_q;
	logic [11:0]       w_q;
	logic [15:0]       step_q, pause_q;
	logic [PROD_W-1:0] q_w;
	logic [2:0]        pick;
	logic              grp_bl, grp_btn, unsup;
	logic [7:0]        alpha, raw_sel, ch_sel, coef;
	logic [7:0]        luma;
	logic [11:0]       max_sel;
	logic [6:0]        pct;
	logic [17:0]       ramp_total;
	logic [15:0]       emit_val;

	// output register
	logic        out_valid_q;
	logic [3:0]  out_tgt_q;
	logic [15:0] out_val_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	// ---------------------------------------------------------------- configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_def_q <= STEP_RST;
			lcd_max_q  <= LCD_RST;
			led_max_q  <= LED_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				CFG_STEP: step_def_q <= pwdata[11:0];
				CFG_LCD:  lcd_max_q  <= pwdata[11:0];
				CFG_LED:  led_max_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			CFG_STEP: prdata = 32'(step_def_q);
			CFG_LCD:  prdata = 32'(lcd_max_q);
			CFG_LED:  prdata = 32'(led_max_q);
			default:  prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- request intake
	assign s_axis_tready = !busy_q;
	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign in_type  = s_axis_tuser;
	assign in_argb  = s_axis_tdata[31:0];
	assign in_timed = s_axis_tdata[32];
	assign in_on    = s_axis_tdata[48:33];
	assign in_off   = s_axis_tdata[64:49];

	// cache the request in its own slot; unsupported types leave the cache alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_color_q[s] <= '0;
				slot_timed_q[s] <= 1'b0;
				slot_on_q[s]    <= '0;
				slot_off_q[s]   <= '0;
			end
		end else if (in_acc && in_type < 3'(NUM_SLOTS)) begin
			slot_color_q[in_type] <= in_argb;
			slot_timed_q[in_type] <= in_timed;
			slot_on_q[in_type]    <= in_on;
			slot_off_q[in_type]   <= in_off;
		end
	end

	// ---------------------------------------------------------------- decode helpers
	assign grp_bl  = (type_q == TYPE_BACKLIGHT);
	assign grp_btn = (type_q == TYPE_BUTTONS);
	assign unsup   = (type_q > TYPE_BUTTONS);

	// white group shows its first lit slot, else the request itself
	always_comb begin
		pick = unsup ? 3'd0 : type_q;
		if (type_q <= TYPE_BATTERY) begin
			for (int s = 2; s >= 0; s--) begin
				if (slot_color_q[s][23:0] != 24'd0)
					pick = 3'(s);
			end
		end
	end

	assign alpha = color_q[31:24];

	always_comb begin
		case (uw.chan)
			CH_R: begin
				raw_sel = color_q[23:16];
				ch_sel  = ch_q[0];
				coef    = LUMA_WR;
			end
			CH_G: begin
				raw_sel = color_q[15:8];
				ch_sel  = ch_q[1];
				coef    = LUMA_WG;
			end
			default: begin
				raw_sel = color_q[7:0];
				ch_sel  = ch_q[2];
				coef    = LUMA_WB;
			end
		endcase
	end

	assign luma       = acc_q[15:8];
	assign max_sel    = grp_bl ? lcd_max_q : 12'(led_max_q);
	assign pct        = (i_q < RAMP_LEN) ? ramp_pct(3'(i_q)) : PCT_FULL;
	assign ramp_total = 18'(step_def_q) * 18'(TWO_N);

	// ---------------------------------------------------------------- divide unit
	llpc_cdiv #(
		.DIV_B(TWO_N)
	) u_cdiv (
		.clk  (clk),
		.x    (prod_q),
		.sel_b(dsel_q),
		.q    (q_w)
	);

	// ---------------------------------------------------------------- sequencer
	assign uw       = ucode_rom(pc_q);
	assign is_emit  = (uw.op == OP_EMIT);
	assign out_free = !out_valid_q || m_axis_tready;
	// an emit step holds until the output register can take the beat
	assign advance  = busy_q && (!is_emit || out_free);
	assign emit_go  = advance && is_emit;

	always_comb begin
		case (uw.cond)
			C_UNSUP:     jump = unsup;
			C_GRP_BL:    jump = grp_bl;
			C_GRP_BTN:   jump = grp_btn;
			C_NOT_TIMED: jump = !timed_q;
			C_MORE:      jump = (i_q != I_LAST);
			default:     jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
				i_q    <= '0;
			end else if (advance) begin
				if (emit_go && uw.last) begin
					busy_q <= 1'b0;
					pc_q   <= '0;
				end else if (jump) begin
					pc_q <= uw.jaddr;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
				if (emit_go && uw.vsrc == V_DUTY)
					i_q <= i_q + 1'b1;
			end
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (in_acc)
			type_q <= in_type;
		if (busy_q) begin
			case (uw.op)
				OP_PICK: begin
					color_q <= slot_color_q[pick];
					timed_q <= slot_timed_q[pick];
					on_q    <= slot_on_q[pick];
					off_q   <= slot_off_q[pick];
				end
				OP_MULA: begin
					prod_q <= PROD_W'(raw_sel) * PROD_W'(alpha);
					dsel_q <= 1'b0;
				end
				OP_TAKEA: begin
					case (uw.chan)
						CH_R:    ch_q[0] <= 8'(q_w);
						CH_G:    ch_q[1] <= 8'(q_w);
						default: ch_q[2] <= 8'(q_w);
					endcase
				end
				OP_MAC: begin
					acc_q <= ((uw.chan == CH_R) ? 16'd0 : acc_q) + 16'(coef) * 16'(ch_sel);
				end
				OP_MULM: begin
					prod_q <= PROD_W'(luma) * PROD_W'(max_sel);
					dsel_q <= 1'b0;
				end
				OP_TAKEW: w_q <= 12'(q_w);
				OP_LDON: begin
					prod_q <= PROD_W'(on_q);
					dsel_q <= 1'b1;
				end
				OP_STEP: begin
					// short on-time: shrink the step, drop the pause at full brightness
					if (18'(on_q) < ramp_total) begin
						step_q  <= 16'(q_w);
						pause_q <= '0;
					end else begin
						step_q  <= 16'(step_def_q);
						pause_q <= 16'(18'(on_q) - ramp_total);
					end
				end
				OP_MULD: begin
					prod_q <= PROD_W'(pct) * PROD_W'(w_q);
					dsel_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- output beat
	always_comb begin
		case (uw.vsrc)
			V_ONE:   emit_val = 16'd1;
			V_W:     emit_val = 16'(w_q);
			V_DUTY:  emit_val = 16'(q_w);
			V_OFF:   emit_val = off_q;
			V_PAUSE: emit_val = pause_q;
			V_STEP:  emit_val = step_q;
			default: emit_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_tgt_q  <= uw.tgt;
			out_val_q  <= emit_val;
			out_idx_q  <= (uw.vsrc == V_DUTY) ? 3'(i_q) : 3'd0;
			out_last_q <= uw.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_idx_q, out_val_q};
	assign m_axis_tuser  = out_tgt_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/llpc_checker.sv =====
module llpc_props
	import llpc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a request occupies the sequencer, so the input drops ready once it is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while previous one in progress");

	a_unsup_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == TGT_UNSUP |-> m_axis_tlast)
		else $error("unsupported result not marked last");

	a_duty_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == TGT_DUTY |-> !m_axis_tlast)
		else $error("duty write ended a request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled output beat changed");

endmodule

bind led_light_priority_controller llpc_props u_llpc_props (.*);
